@@ src/hsvr_pkg.sv @@
// Shared constants, payload types and hue sector codes for the HSV to RGB converter.
package hsvr_pkg;

  // Channel width of saturation, brightness and the color outputs (8..24).
  localparam int CHANNEL_BITS = 16;

  // Hue in 1/64 degree units.
  localparam int HUE_BITS   = 15;
  localparam int HueSector  = 3840;            // 60 degrees
  localparam int HueFull    = 6 * HueSector;   // 360 degrees

  // Hue weight (sector-local triangle wave, 0..HueSector).
  localparam int W_BITS = $clog2(HueSector + 1);

  // Rounding offset for the saturation * brightness product.
  localparam longint unsigned ChHalf = 64'd1 << (CHANNEL_BITS - 1);

  // Second-component product: chroma * weight + HueSector/2.
  localparam int X_BITS = CHANNEL_BITS + W_BITS;

  // Division by 3840 = 256 * 15: shift by 8, then multiply by a reciprocal of 15.
  localparam int DIV_SHIFT  = 8;
  localparam int Y_BITS     = X_BITS - DIV_SHIFT;
  localparam int K_BITS     = Y_BITS + 4;
  localparam longint unsigned Recip15 = ((64'd1 << K_BITS) + 64'd14) / 64'd15;
  localparam int RECIP_BITS = K_BITS - 3;
  localparam int Q_BITS     = Y_BITS + RECIP_BITS;

  // Pipeline depth: product, second product, reciprocal product, output.
  localparam int STAGES = 4;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic                gray;
    sector_t             sector;
    logic [W_BITS-1:0]   weight;
  } hue_info_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] valid;
  } pipe_ctrl_t;

endpackage

@@ src/hsvr_hue_decode.sv @@
// Hue decode: sector, out-of-range flag and triangle-wave weight.
module hsvr_hue_decode
  import hsvr_pkg::*;
(
  input  logic [HUE_BITS-1:0] hue,
  output hue_info_t           info
);

  logic [HUE_BITS-1:0] phase;
  logic [HUE_BITS-1:0] weight_full;

  always_comb begin
    info.gray = hue > HUE_BITS'(HueFull);

    // boundaries belong to the lower sector
    if (hue > HUE_BITS'(5 * HueSector)) begin
      info.sector = SECTOR_5;
    end else if (hue > HUE_BITS'(4 * HueSector)) begin
      info.sector = SECTOR_4;
    end else if (hue > HUE_BITS'(3 * HueSector)) begin
      info.sector = SECTOR_3;
    end else if (hue > HUE_BITS'(2 * HueSector)) begin
      info.sector = SECTOR_2;
    end else if (hue > HUE_BITS'(HueSector)) begin
      info.sector = SECTOR_1;
    end else begin
      info.sector = SECTOR_0;
    end

    // hue mod 120 degrees
    if (hue >= HUE_BITS'(6 * HueSector)) begin
      phase = hue - HUE_BITS'(6 * HueSector);
    end else if (hue >= HUE_BITS'(4 * HueSector)) begin
      phase = hue - HUE_BITS'(4 * HueSector);
    end else if (hue >= HUE_BITS'(2 * HueSector)) begin
      phase = hue - HUE_BITS'(2 * HueSector);
    end else begin
      phase = hue;
    end

    // S - |phase - S|; junk when gray, which ignores it
    if (phase >= HUE_BITS'(HueSector)) begin
      weight_full = HUE_BITS'(2 * HueSector) - phase;
    end else begin
      weight_full = phase;
    end
    info.weight = weight_full[W_BITS-1:0];
  end

endmodule

@@ src/hsvr_pipe_ctrl.sv @@
// Valid bits and per-stage load enables for the converter pipeline.
module hsvr_pipe_ctrl
  import hsvr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_stall,
  output pipe_ctrl_t ctrl
);

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] valid_next;
  logic [STAGES-1:0] ready;

  always_comb begin
    // a stage takes new data when empty or when its content moves on
    ready[STAGES-1] = !valid[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
    for (int i = 0; i < STAGES; i++) begin
      if (ready[i]) begin
        valid_next[i] = (i == 0) ? in_valid : valid[(i == 0) ? 0 : i - 1];
      end else begin
        valid_next[i] = valid[i];
      end
    end
    ctrl.load  = ready;
    ctrl.valid = valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

@@ src/hsv_to_rgb_converter_top.sv @@
// Top level of the HSV to RGB converter: four-stage fixed-point datapath.
//
// Converts one hue/saturation/value transaction into one red/green/blue
// transaction. Hue is in 1/64 degree units (23040 = 360 degrees); saturation,
// brightness and the outputs are unsigned Q0.16. Throughput is one
// transaction per clock while rgb_stall is low. The four register stages
// are: saturation x brightness (chroma), chroma x hue weight, reciprocal
// multiply for the divide by 3840, and the channel select/add into the
// output register. Each stage holds its content only while the stage after
// it is full and blocked, so bubbles are squeezed out and a stalled rgb
// output still lets earlier stages fill. A hue above 360 degrees gives gray
// (all channels equal brightness minus chroma); a hue on a 60-degree
// boundary belongs to the lower sector. The block keeps no state between
// transactions and reset only clears the valid bits.
module hsv_to_rgb_converter_top
  import hsvr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic hsv_valid,
  output logic hsv_stall,
  input  hsv_t hsv,
  output logic rgb_valid,
  input  logic rgb_stall,
  output rgb_t rgb
);

  pipe_ctrl_t ctrl;
  hue_info_t  in_info;

  hsvr_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsv_valid),
    .out_stall (rgb_stall),
    .ctrl      (ctrl)
  );

  hsvr_hue_decode u_hue (
    .hue  (hsv.hue),
    .info (in_info)
  );

  assign hsv_stall = !ctrl.load[0];
  assign rgb_valid = ctrl.valid[STAGES-1];

  // Stage A: chroma = round(saturation * brightness)
  logic [2*CHANNEL_BITS-1:0] a_prod;
  logic [CHANNEL_BITS-1:0]   a_chroma;
  logic [CHANNEL_BITS-1:0]   a_bright;
  hue_info_t                 a_info;

  assign a_prod = (2*CHANNEL_BITS)'(hsv.saturation) * (2*CHANNEL_BITS)'(hsv.brightness)
                + (2*CHANNEL_BITS)'(ChHalf);

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      a_chroma <= a_prod[2*CHANNEL_BITS-1:CHANNEL_BITS];
      a_bright <= hsv.brightness;
      a_info   <= in_info;
    end
  end

  // Stage B: chroma * weight + half sector, and offset m
  logic [X_BITS-1:0]       b_x;
  logic [CHANNEL_BITS-1:0] b_chroma;
  logic [CHANNEL_BITS-1:0] b_offset;
  logic                    b_gray;
  sector_t                 b_sector;

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      b_x      <= X_BITS'(a_chroma) * X_BITS'(a_info.weight) + X_BITS'(HueSector / 2);
      b_chroma <= a_chroma;
      b_offset <= a_bright - a_chroma;  // chroma never exceeds brightness
      b_gray   <= a_info.gray;
      b_sector <= a_info.sector;
    end
  end

  // Stage C: x / 3840 as (x >> 8) * ceil(2^K / 15), quotient taken at stage D
  logic [Y_BITS-1:0]       b_y;
  logic [Q_BITS-1:0]       c_prod;
  logic [CHANNEL_BITS-1:0] c_chroma;
  logic [CHANNEL_BITS-1:0] c_offset;
  logic                    c_gray;
  sector_t                 c_sector;

  assign b_y = b_x[X_BITS-1:DIV_SHIFT];

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      c_prod   <= Q_BITS'(b_y) * Q_BITS'(Recip15);
      c_chroma <= b_chroma;
      c_offset <= b_offset;
      c_gray   <= b_gray;
      c_sector <= b_sector;
    end
  end

  // Stage D: channel select and offset add into the output register
  logic [CHANNEL_BITS-1:0] c_second;
  logic [CHANNEL_BITS-1:0] c_hi;
  logic [CHANNEL_BITS-1:0] c_mid;
  rgb_t                    rgb_next;

  assign c_second = c_prod[K_BITS +: CHANNEL_BITS];
  assign c_hi     = c_offset + c_chroma;
  assign c_mid    = c_offset + c_second;

  always_comb begin
    rgb_next.red   = c_offset;
    rgb_next.green = c_offset;
    rgb_next.blue  = c_offset;
    if (!c_gray) begin
      unique case (c_sector)
        SECTOR_0: begin
          rgb_next.red   = c_hi;
          rgb_next.green = c_mid;
        end
        SECTOR_1: begin
          rgb_next.red   = c_mid;
          rgb_next.green = c_hi;
        end
        SECTOR_2: begin
          rgb_next.green = c_hi;
          rgb_next.blue  = c_mid;
        end
        SECTOR_3: begin
          rgb_next.green = c_mid;
          rgb_next.blue  = c_hi;
        end
        SECTOR_4: begin
          rgb_next.red   = c_mid;
          rgb_next.blue  = c_hi;
        end
        default: begin
          rgb_next.red   = c_hi;
          rgb_next.blue  = c_mid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      rgb <= rgb_next;
    end
  end

endmodule

@@ dv/tb_hsv_to_rgb_converter_top.sv @@
// Self-checking testbench for the HSV to RGB converter top level.
module tb_hsv_to_rgb_converter_top
  import hsvr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch with no transaction on either side before the run is
  // declared hung. The worst legal gap is the long output hold-off plus
  // pipeline refill, so this is many times over.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int NUM_DIRECTED = 23;

  logic clk = 1'b0;
  logic rst;
  logic hsv_valid;
  logic hsv_stall;
  hsv_t hsv;
  logic rgb_valid;
  logic rgb_stall;
  rgb_t rgb;

  // Colors predicted for accepted transactions, oldest first.
  rgb_t pending_rgb[$];

  int  color_errors = 0;
  int  rgb_seen = 0;
  int  idle_cycles = 0;
  int  hold_cycles = 0;    // set by the sender, served by the receiver
  bit  quiet = 1'b0;       // last part of the run: no idling on either side
  bit  sender_idle_ok = 1'b1;

  hsv_to_rgb_converter_top dut (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  always #10 clk = ~clk;

  // ------------------------------------------------------------------
  // Color predictor: chroma = s*v rounded, m = v - chroma, second component
  // from a triangle wave over pairs of 60-degree sectors, then the sector
  // picks which channels get chroma and second. Hue past 360 deg is gray.
  // ------------------------------------------------------------------
  function automatic rgb_t convert_hsv(hsv_t px);
    longint unsigned sat, val, chroma, m, p, d, second, hue;
    sector_t sec;
    rgb_t c;
    hue = px.hue;
    sat = px.saturation;
    val = px.brightness;
    chroma = (sat * val + ChHalf) >> CHANNEL_BITS;
    m = val - chroma;
    c.red = CHANNEL_BITS'(m);
    c.green = CHANNEL_BITS'(m);
    c.blue = CHANNEL_BITS'(m);
    if (hue <= HueFull) begin
      p = hue % (2 * HueSector);
      d = (p >= HueSector) ? (p - HueSector) : (HueSector - p);
      second = (chroma * (HueSector - d) + HueSector / 2) / HueSector;
      // boundary hues fall into the lower sector
      sec = (hue == 0) ? SECTOR_0 : sector_t'((hue - 1) / HueSector);
      case (sec)
        SECTOR_0: begin
          c.red = CHANNEL_BITS'(m + chroma);
          c.green = CHANNEL_BITS'(m + second);
        end
        SECTOR_1: begin
          c.red = CHANNEL_BITS'(m + second);
          c.green = CHANNEL_BITS'(m + chroma);
        end
        SECTOR_2: begin
          c.green = CHANNEL_BITS'(m + chroma);
          c.blue = CHANNEL_BITS'(m + second);
        end
        SECTOR_3: begin
          c.green = CHANNEL_BITS'(m + second);
          c.blue = CHANNEL_BITS'(m + chroma);
        end
        SECTOR_4: begin
          c.red = CHANNEL_BITS'(m + second);
          c.blue = CHANNEL_BITS'(m + chroma);
        end
        default: begin
          c.red = CHANNEL_BITS'(m + chroma);
          c.blue = CHANNEL_BITS'(m + second);
        end
      endcase
    end
    return c;
  endfunction

  // ------------------------------------------------------------------
  // Directed cases. Where the color is obvious it is typed in; the rest
  // go through the predictor.
  // ------------------------------------------------------------------
  typedef struct {
    hsv_t px;
    bit   typed;
    rgb_t rgb;
  } color_case_t;

  color_case_t directed_rows [NUM_DIRECTED] = '{
    // black: zero brightness
    '{'{0,     16'h0000, 16'h0000}, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    // full red at hue 0: chroma = 0xFFFE, m = 1
    '{'{0,     16'hFFFF, 16'hFFFF}, 1'b1, '{16'hFFFF, 16'h0001, 16'h0001}},
    // hue past full circle: gray, m only
    '{'{32767, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0001, 16'h0001, 16'h0001}},
    '{'{23041, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0001, 16'h0001, 16'h0001}},
    // exactly 360 deg: sector 5 with no second component
    '{'{23040, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'hFFFF, 16'h0001, 16'h0001}},
    // zero saturation: every channel equals brightness
    '{'{12345, 16'h0000, 16'hFFFF}, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF}},
    // 60 deg boundary stays in sector 0, second = chroma
    '{'{3840,  16'hFFFF, 16'hFFFF}, 1'b1, '{16'hFFFF, 16'hFFFF, 16'h0001}},
    // gray hue with zero brightness
    '{'{30000, 16'h1234, 16'h0000}, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    // sector midpoints and boundaries, checked by the predictor
    '{'{1,     16'h8000, 16'h8000}, 1'b0, '{0, 0, 0}},
    '{'{1920,  16'hA5A5, 16'h5A5A}, 1'b0, '{0, 0, 0}},
    '{'{3841,  16'hC000, 16'hF00F}, 1'b0, '{0, 0, 0}},
    '{'{5760,  16'h7FFF, 16'hFFFF}, 1'b0, '{0, 0, 0}},
    '{'{7680,  16'hFFFF, 16'h8001}, 1'b0, '{0, 0, 0}},
    '{'{9600,  16'h3333, 16'hCCCC}, 1'b0, '{0, 0, 0}},
    '{'{11520, 16'hFFFF, 16'hFFFF}, 1'b0, '{0, 0, 0}},
    '{'{13440, 16'h0001, 16'hFFFF}, 1'b0, '{0, 0, 0}},
    '{'{15360, 16'hFEDC, 16'h1234}, 1'b0, '{0, 0, 0}},
    '{'{17280, 16'hFFFF, 16'h0001}, 1'b0, '{0, 0, 0}},
    '{'{19200, 16'h8000, 16'hFFFF}, 1'b0, '{0, 0, 0}},
    '{'{21120, 16'hABCD, 16'hEF01}, 1'b0, '{0, 0, 0}},
    '{'{23039, 16'hFFFF, 16'hFFFF}, 1'b0, '{0, 0, 0}},
    '{'{16384, 16'h5555, 16'hAAAA}, 1'b0, '{0, 0, 0}},
    '{'{7,     16'hFFFF, 16'h0001}, 1'b0, '{0, 0, 0}}
  };

  function automatic logic [CHANNEL_BITS-1:0] random_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHANNEL_BITS'($urandom());
    endcase
  endfunction

  // Mostly hues on the circle, some near the sector boundaries, some gray.
  function automatic hsv_t random_pixel();
    hsv_t px;
    int h;
    case ($urandom_range(0, 9))
      0: h = $urandom_range(HueFull + 1, (1 << HUE_BITS) - 1);
      1, 2: begin
        h = $urandom_range(0, 6) * HueSector + $urandom_range(0, 2) - 1;
        if (h < 0) h = 0;
      end
      default: h = $urandom_range(0, HueFull);
    endcase
    px.hue = HUE_BITS'(h);
    px.saturation = random_channel();
    px.brightness = random_channel();
    return px;
  endfunction

  // One input transaction: optional idle burst, then offer until accepted.
  // The predicted color is queued at the accepting edge.
  task automatic send_pixel(input hsv_t px, input bit typed, input rgb_t typed_rgb);
    if (!quiet && sender_idle_ok && $urandom_range(0, 5) == 0) begin
      hsv_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    hsv <= px;
    hsv_valid <= 1'b1;
    do @(posedge clk); while (hsv_stall !== 1'b0);
    pending_rgb.push_back(typed ? typed_rgb : convert_hsv(px));
  endtask

  task automatic send_random(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      sender_idle_ok = ((i / 64) % 3 != 2);  // every third stretch runs flat out
      if (i == 200 && !quiet) hold_cycles = HOLD_OFF_CYCLES;
      send_pixel(random_pixel(), 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  task automatic flag_color_error(input string what, input longint got, input longint exp);
    $display("[%0t] color error on result %0d: %s got %0h expected %0h",
             $realtime, rgb_seen, what, got, exp);
    color_errors++;
  endtask

  // ------------------------------------------------------------------
  // Sender: reset, directed cases, random stream with a long output
  // hold-off, a full drain pause, more random, then a flat-out tail.
  // ------------------------------------------------------------------
  initial begin : hsv_sender
    int i;
    rst <= 1'b1;
    hsv_valid <= 1'b0;
    hsv <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++)
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].rgb);

    // the receiver holds off partway through, so the pipe fills and stalls hsv
    send_random(700);

    // pause until every outstanding transaction has come out
    hsv_valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    send_random(700);

    quiet = 1'b1;
    send_random(300);

    hsv_valid <= 1'b0;
    wait_drained();
    repeat (STAGES + 4) @(posedge clk);
    if (color_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ------------------------------------------------------------------
  // Receiver: random stall bursts with calm stretches, plus the long
  // hold-off on request.
  // ------------------------------------------------------------------
  initial begin : rgb_receiver
    int cyc;
    cyc = 0;
    rgb_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_cycles > 0) begin
        rgb_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        rgb_stall <= 1'b0;
      end else if (!quiet && (cyc / 97) % 3 != 1 && $urandom_range(0, 7) == 0) begin
        rgb_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        rgb_stall <= 1'b0;
      end
    end
  end

  // Output checker: each rgb transaction against the oldest prediction.
  always @(posedge clk) begin : rgb_check
    rgb_t want;
    if (!rst && rgb_valid === 1'b1 && rgb_stall === 1'b0) begin
      if (pending_rgb.size() == 0) begin
        flag_color_error("unexpected transaction, rgb", rgb, 0);
      end else begin
        want = pending_rgb.pop_front();
        if (rgb.red !== want.red) flag_color_error("red", rgb.red, want.red);
        if (rgb.green !== want.green) flag_color_error("green", rgb.green, want.green);
        if (rgb.blue !== want.blue) flag_color_error("blue", rgb.blue, want.blue);
      end
      rgb_seen++;
    end
  end

  // Watchdog: counts cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((hsv_valid === 1'b1 && hsv_stall === 1'b0) ||
        (rgb_valid === 1'b1 && rgb_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d results pending",
               $realtime, idle_cycles, pending_rgb.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
